/* src/cbmirq_pkg.sv */
// Shared types, codes and constants for the cartridge bank mapper.
`default_nettype none

package cbmirq_pkg;

    localparam int REG_COUNT = 16;
    localparam int REG_SEL_W = $clog2(REG_COUNT);

    localparam logic [7:0]           BANK_SPLIT = 8'h40;
    localparam logic [7:0]           BANK_LAST  = 8'hFF;
    localparam logic [REG_SEL_W-1:0] ADD_REG    = REG_SEL_W'(4'hB);

    localparam logic [15:0] ADDR_IRQ_LO    = 16'hD600;
    localparam logic [15:0] ADDR_IRQ_HI    = 16'hD700;
    localparam logic [15:0] ADDR_IRQ_ACK   = 16'hD800;
    localparam logic [15:0] ADDR_IRQ_CTRL  = 16'hD900;
    localparam logic [15:0] SEL_MASK       = 16'h0F00;

    typedef enum logic [2:0] {
        OP_WRITE    = 3'd0,
        OP_READ     = 3'd1,
        OP_TICK     = 3'd2,
        OP_CPU_XLAT = 3'd3,
        OP_PAT_XLAT = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        TGT_CHIP0 = 3'd0,
        TGT_CHIP1 = 3'd1,
        TGT_WRAM  = 3'd2,
        TGT_PRAM  = 3'd3,
        TGT_NONE  = 3'd4
    } target_t;

    typedef struct packed {
        target_t     tgt;
        logic [7:0]  bank;
        logic [12:0] offset;
    } xlat_t;

    // A ROM window register at or above the split value selects the second chip.
    function automatic xlat_t rom_window(input logic [7:0] v, input logic [15:0] addr);
        xlat_t r;
        r.offset = addr[12:0];
        if (v >= BANK_SPLIT)
        begin
            r.tgt  = TGT_CHIP1;
            r.bank = v - BANK_SPLIT;
        end
        else
        begin
            r.tgt  = TGT_CHIP0;
            r.bank = {2'b00, v[5:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/cartridge_bank_mapper_with_irq_top.sv */
// Top level of the cartridge bank mapper with its cycle-counting interrupt.
`default_nettype none

// The mapper takes one request beat per cycle: a CPU write, a CPU read, a
// cycle tick or an address translation, and returns exactly one result beat
// for each. A request is captured in an input register, worked out by a
// single pass of short logic against the mapper state, and the result lands
// in an output register, so that a new item may be accepted in every cycle
// while the output side keeps up. When the output is stalled the input
// register still takes one more beat before the input stall rises. The state
// (sixteen bank registers, the 16-bit reload value, the 17-bit counter and
// the interrupt flags) is updated at the same edge that loads the result, so
// each request sees the effect of every earlier one. Every result carries
// the interrupt line as it stands after that request; the target reads as
// unmapped, with bank and offset zero, for anything that is not a
// translation, and the read data is zero for anything that is not a read.
// Mirroring is not handled here.
module cartridge_bank_mapper_with_irq_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  opcode,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  data,
    input  wire logic [7:0]  cycles,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       read_data,
    output logic             irq_line,
    output logic [2:0]       target,
    output logic [7:0]       bank,
    output logic [12:0]      offset
);
    import cbmirq_pkg::*;

    // Input register.
    logic        s1_valid_reg;
    logic [2:0]  s1_opcode_reg;
    logic [15:0] s1_address_reg;
    logic [7:0]  s1_data_reg;
    logic [7:0]  s1_cycles_reg;

    // Mapper state.
    logic [7:0]  bank_regs_reg [REG_COUNT];
    logic [7:0]  bank_regs_next [REG_COUNT];
    logic [15:0] irq_reload_reg, irq_reload_next;
    logic [16:0] irq_counter_reg, irq_counter_next;
    logic        irq_counting_reg, irq_counting_next;
    logic        enable_after_ack_reg, enable_after_ack_next;
    logic        irq_asserted_reg, irq_asserted_next;

    // Result register.
    logic        out_valid_reg;
    logic [7:0]  read_data_reg, read_data_next;
    logic [2:0]  target_reg;
    logic [7:0]  bank_reg;
    logic [12:0] offset_reg;
    xlat_t       xlat_next;

    logic                 in_accept;
    logic                 advance;
    logic [REG_SEL_W-1:0] sel;
    logic [16:0]          tick_sum;
    op_t                  s1_op;

    // The input register moves on whenever the output register is free or
    // is being emptied in the same cycle.
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    assign s1_op    = op_t'(s1_opcode_reg);
    assign sel      = s1_address_reg[11:8];
    assign tick_sum = irq_counter_reg + {9'd0, s1_cycles_reg};

    always_comb
    begin
        bank_regs_next        = bank_regs_reg;
        irq_reload_next       = irq_reload_reg;
        irq_counter_next      = irq_counter_reg;
        irq_counting_next     = irq_counting_reg;
        enable_after_ack_next = enable_after_ack_reg;
        irq_asserted_next     = irq_asserted_reg;
        read_data_next        = 8'd0;
        xlat_next.tgt         = TGT_NONE;
        xlat_next.bank        = 8'd0;
        xlat_next.offset      = 13'd0;

        case (s1_op)
            OP_WRITE:
            begin
                // Writes below the cartridge space change no mapper state.
                if (s1_address_reg[15])
                begin
                    bank_regs_next[sel] = s1_data_reg;
                    if (s1_address_reg == ADDR_IRQ_LO)
                    begin
                        irq_reload_next[7:0] = s1_data_reg;
                    end
                    else if (s1_address_reg == ADDR_IRQ_HI)
                    begin
                        irq_reload_next[15:8] = s1_data_reg;
                    end
                    else if (s1_address_reg == ADDR_IRQ_CTRL)
                    begin
                        irq_counter_next      = {1'b0, irq_reload_reg};
                        irq_counting_next     = s1_data_reg[1];
                        enable_after_ack_next = s1_data_reg[0];
                        irq_asserted_next     = 1'b0;
                    end
                    else if (s1_address_reg == ADDR_IRQ_ACK)
                    begin
                        irq_counting_next = enable_after_ack_reg;
                        irq_asserted_next = 1'b0;
                    end
                end
            end
            OP_READ:
            begin
                read_data_next = bank_regs_reg[sel] + bank_regs_reg[ADD_REG];
            end
            OP_TICK:
            begin
                // A carry into bit 16 raises the interrupt and reloads.
                if (irq_counting_reg)
                begin
                    if (tick_sum[16])
                    begin
                        irq_asserted_next = 1'b1;
                        irq_counter_next  = {1'b0, irq_reload_reg};
                    end
                    else
                    begin
                        irq_counter_next = tick_sum;
                    end
                end
            end
            OP_CPU_XLAT:
            begin
                if (s1_address_reg inside {[16'hE000:16'hFFFF]})
                begin
                    xlat_next.tgt    = TGT_CHIP1;
                    xlat_next.bank   = BANK_LAST;
                    xlat_next.offset = s1_address_reg[12:0];
                end
                else if (s1_address_reg inside {[16'hC000:16'hDFFF]})
                begin
                    xlat_next = rom_window(bank_regs_reg[4], s1_address_reg);
                end
                else if (s1_address_reg inside {[16'hA000:16'hBFFF]})
                begin
                    xlat_next = rom_window(bank_regs_reg[3], s1_address_reg);
                end
                else if (s1_address_reg inside {[16'h8000:16'h9FFF]})
                begin
                    xlat_next = rom_window(bank_regs_reg[2], s1_address_reg);
                end
                else if (s1_address_reg inside {[16'h7000:16'h7FFF]})
                begin
                    xlat_next.tgt    = TGT_WRAM;
                    xlat_next.bank   = 8'd2;
                    xlat_next.offset = {1'b0, s1_address_reg[11:0]};
                end
                else if (s1_address_reg inside {[16'h6000:16'h6FFF]})
                begin
                    xlat_next.tgt    = TGT_WRAM;
                    xlat_next.bank   = {7'd0, bank_regs_reg[0][0]};
                    xlat_next.offset = {1'b0, s1_address_reg[11:0]};
                end
            end
            OP_PAT_XLAT:
            begin
                if (s1_address_reg inside {[16'h0000:16'h0FFF]})
                begin
                    xlat_next.tgt    = TGT_PRAM;
                    xlat_next.bank   = {7'd0, bank_regs_reg[5][0]};
                    xlat_next.offset = {1'b0, s1_address_reg[11:0]};
                end
                else if (s1_address_reg inside {[16'h1000:16'h1FFF]})
                begin
                    xlat_next.tgt    = TGT_PRAM;
                    xlat_next.bank   = 8'd0;
                    xlat_next.offset = {1'b0, s1_address_reg[11:0]};
                end
            end
            default:
            begin
                // Undefined requests leave the state alone.
            end
        endcase
    end

    // Control and mapper state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            irq_reload_reg       <= '0;
            irq_counter_reg      <= '0;
            irq_counting_reg     <= 1'b0;
            enable_after_ack_reg <= 1'b0;
            irq_asserted_reg     <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++)
            begin
                bank_regs_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                bank_regs_reg        <= bank_regs_next;
                irq_reload_reg       <= irq_reload_next;
                irq_counter_reg      <= irq_counter_next;
                irq_counting_reg     <= irq_counting_next;
                enable_after_ack_reg <= enable_after_ack_next;
                irq_asserted_reg     <= irq_asserted_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_opcode_reg  <= opcode;
            s1_address_reg <= address;
            s1_data_reg    <= data;
            s1_cycles_reg  <= cycles;
        end
        if (advance)
        begin
            read_data_reg <= read_data_next;
            target_reg    <= xlat_next.tgt;
            bank_reg      <= xlat_next.bank;
            offset_reg    <= xlat_next.offset;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign irq_line  = irq_asserted_reg;
    assign target    = target_reg;
    assign bank      = bank_reg;
    assign offset    = offset_reg;

    // The counter reloads from a 16-bit value and never keeps a carry.
    assert property (@(posedge clk) disable iff (!rst_n) !irq_counter_reg[16])
        else $error("interrupt counter kept a carry in bit 16");

    // An acknowledge or control write always drops the interrupt.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_opcode_reg == OP_WRITE &&
        (s1_address_reg == ADDR_IRQ_ACK || s1_address_reg == ADDR_IRQ_CTRL)
        |=> !irq_line)
        else $error("interrupt still asserted after acknowledge");

    // Only translations produce a mapped target.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_opcode_reg != OP_CPU_XLAT && s1_opcode_reg != OP_PAT_XLAT
        |=> target == TGT_NONE && bank == 8'd0 && offset == 13'd0)
        else $error("mapped target on a request that is not a translation");

    // The interrupt can only rise through a tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(irq_asserted_reg) |-> $past(advance) && $past(s1_opcode_reg) == OP_TICK)
        else $error("interrupt raised without a tick");

endmodule

`default_nettype wire
